[rtl/duration_text_parser_assert.svh]
// Assertion helpers for the duration text parser.
`ifndef DURATION_TEXT_PARSER_ASSERT_SVH
`define DURATION_TEXT_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define DTP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("duration_text_parser: check failed");
`define DTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("duration_text_parser: implication failed");
`else
`define DTP_ASSERT(lbl, clk, rst_n, prop)
`define DTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/dtp_pkg.sv]
package dtp_pkg;

  localparam int unsigned SecW   = 31;
  localparam int unsigned SecNumW = 7;

  localparam logic [7:0] CH_END    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_M_UP   = 8'h4D;
  localparam logic [7:0] CH_M_LOW  = 8'h6D;
  localparam logic [7:0] CH_S_UP   = 8'h53;
  localparam logic [7:0] CH_S_LOW  = 8'h73;

  localparam logic [SecNumW-1:0] SEC_LIMIT = 7'd60;
  localparam logic [SecNumW-1:0] SEC_SAT   = 7'd64;

  typedef struct packed {
    logic [SecW-1:0] total_seconds;
    logic            parse_status;
  } dtp_result_t;

endpackage

[rtl/dtp_in_if.sv]
interface dtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

[rtl/dtp_out_if.sv]
interface dtp_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] total_seconds;
  logic        parse_status;

  modport source (output valid, output total_seconds, output parse_status, input ready);
  modport sink   (input valid, input total_seconds, input parse_status, output ready);
endinterface

[rtl/dtp_core.sv]
module dtp_core import dtp_pkg::*; #(
  parameter int unsigned MAX_BODY_LEN = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  output dtp_result_t result_o
);

  localparam int unsigned LenW = $clog2(MAX_BODY_LEN + 2);

  typedef enum logic [1:0] {PH_LEAD, PH_BODY, PH_TRAIL} phase_e;

  phase_e              phase_q, phase_d;
  logic [LenW-1:0]     len_q, len_d;
  logic [SecW-1:0]     first_q, first_d;
  logic [SecNumW-1:0]  sec_q, sec_d;
  logic                first_seen_q, first_seen_d;
  logic                sec_seen_q, sec_seen_d;
  logic                colon_q, colon_d;
  logic                minute_q, minute_d;
  logic                suffix_q, suffix_d;
  logic                fail_q, fail_d;

  logic                is_space, is_digit;
  logic [3:0]          digit;
  logic [SecW+3:0]     first_x10;
  logic [9:0]          sec_x10;
  logic                timed;

  assign is_space = (byte_i == CH_SPACE) || (byte_i == CH_TAB) || (byte_i == CH_LF) ||
                    (byte_i == CH_VT) || (byte_i == CH_FF) || (byte_i == CH_CR);
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign digit    = byte_i[3:0];
  assign timed    = colon_q || minute_q;

  assign first_x10 = ({4'b0, first_q} << 3) + ({4'b0, first_q} << 1) +
                     {{(SecW){1'b0}}, digit};
  assign sec_x10   = ({3'b0, sec_q} << 3) + ({3'b0, sec_q} << 1) + {6'b0, digit};

  always_comb begin
    phase_d      = phase_q;
    len_d        = len_q;
    first_d      = first_q;
    sec_d        = sec_q;
    first_seen_d = first_seen_q;
    sec_seen_d   = sec_seen_q;
    colon_d      = colon_q;
    minute_d     = minute_q;
    suffix_d     = suffix_q;
    fail_d       = fail_q;
    if (byte_i == CH_END) begin
      phase_d      = PH_LEAD;
      len_d        = '0;
      first_d      = '0;
      sec_d        = '0;
      first_seen_d = 1'b0;
      sec_seen_d   = 1'b0;
      colon_d      = 1'b0;
      minute_d     = 1'b0;
      suffix_d     = 1'b0;
      fail_d       = 1'b0;
    end else if (is_space) begin
      if (phase_q == PH_BODY) phase_d = PH_TRAIL;
    end else begin
      if (phase_q != PH_LEAD && phase_q != PH_BODY) fail_d = 1'b1;
      if (phase_q == PH_LEAD) phase_d = PH_BODY;
      if (len_q <= LenW'(MAX_BODY_LEN)) len_d = len_q + 1'b1;
      priority if (is_digit) begin
        if (suffix_q) begin
          fail_d = 1'b1;
        end else if (timed) begin
          sec_d      = (sec_x10 > {3'b0, SEC_SAT}) ? SEC_SAT : sec_x10[SecNumW-1:0];
          sec_seen_d = 1'b1;
        end else begin
          if (|first_x10[SecW+3:SecW]) fail_d = 1'b1;
          else first_d = first_x10[SecW-1:0];
          first_seen_d = 1'b1;
        end
      end else if (byte_i == CH_COLON) begin
        if (timed || suffix_q || !first_seen_q) fail_d = 1'b1;
        colon_d = 1'b1;
      end else if (byte_i == CH_M_LOW || byte_i == CH_M_UP) begin
        if (timed || suffix_q || !first_seen_q) fail_d = 1'b1;
        minute_d = 1'b1;
      end else if (byte_i == CH_S_LOW || byte_i == CH_S_UP) begin
        if (colon_q || suffix_q) fail_d = 1'b1;
        suffix_d = 1'b1;
      end else begin
        fail_d = 1'b1;
      end
    end
  end

  // Result for an end-of-text byte, from the state before it.
  logic [SecNumW-1:0] sec_used;
  logic [SecW+5:0]    total_timed;
  logic               bad_form, bad_total, ok;
  logic [SecW-1:0]    total;

  assign sec_used    = sec_seen_q ? sec_q : '0;
  assign total_timed = ({6'b0, first_q} << 6) - ({6'b0, first_q} << 2) +
                       {{(SecW-1){1'b0}}, sec_used};

  always_comb begin
    bad_form  = fail_q || (len_q == '0) || (len_q > LenW'(MAX_BODY_LEN)) || !first_seen_q;
    bad_total = 1'b0;
    total     = first_q;
    if (timed) begin
      if (colon_q && !sec_seen_q) bad_form = 1'b1;
      if (minute_q && suffix_q && !sec_seen_q) bad_form = 1'b1;
      if (sec_used >= SEC_LIMIT) bad_form = 1'b1;
      bad_total = |total_timed[SecW+5:SecW];
      total     = total_timed[SecW-1:0];
    end
    ok = !bad_form && !bad_total;
    result_o.total_seconds = ok ? total : '0;
    result_o.parse_status  = !ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_LEAD;
      len_q        <= '0;
      first_q      <= '0;
      sec_q        <= '0;
      first_seen_q <= 1'b0;
      sec_seen_q   <= 1'b0;
      colon_q      <= 1'b0;
      minute_q     <= 1'b0;
      suffix_q     <= 1'b0;
      fail_q       <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      len_q        <= len_d;
      first_q      <= first_d;
      sec_q        <= sec_d;
      first_seen_q <= first_seen_d;
      sec_seen_q   <= sec_seen_d;
      colon_q      <= colon_d;
      minute_q     <= minute_d;
      suffix_q     <= suffix_d;
      fail_q       <= fail_d;
    end
  end

endmodule

[rtl/duration_text_parser.sv]
// Duration text parser: takes one text byte per cycle and, on byte 0, delivers
// one result (seconds and status) for the text collected since the previous
// byte 0. Bytes are registered on input and processed one per cycle against
// the scan state; a result is captured in the output register when its
// terminating byte leaves the input register. The output register holds a
// result until it is taken; text bytes keep flowing meanwhile, and only a
// terminating byte waits while the previous result is still pending.
`include "duration_text_parser_assert.svh"

module duration_text_parser import dtp_pkg::*; #(
  parameter int unsigned MAX_BODY_LEN = 63
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtp_in_if.sink    in_i,
  dtp_out_if.source out_o
);

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        out_valid_q;
  dtp_result_t out_res_q;
  dtp_result_t core_res;
  logic        s1_end, out_free, advance, in_ready;

  assign s1_end   = (s1_byte_q == CH_END);
  assign out_free = !out_valid_q || out_o.ready;
  assign advance  = s1_valid_q && (!s1_end || out_free);
  assign in_ready = !s1_valid_q || advance;

  dtp_core #(.MAX_BODY_LEN(MAX_BODY_LEN)) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (s1_byte_q),
    .result_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) s1_valid_q <= in_i.valid;
      if (advance && s1_end) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) s1_byte_q <= in_i.text_byte;
    if (advance && s1_end) out_res_q <= core_res;
  end

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.total_seconds = out_res_q.total_seconds;
  assign out_o.parse_status  = out_res_q.parse_status;

  `DTP_ASSERT_IMP(a_invalid_zero, clk_i, rst_ni, out_valid_q && out_res_q.parse_status,
                  out_res_q.total_seconds == '0)
  `DTP_ASSERT_IMP(a_stall_has_item, clk_i, rst_ni, !in_ready, s1_valid_q && s1_end)
  `DTP_ASSERT(a_result_from_end, clk_i, rst_ni,
              $rose(out_valid_q) |-> $past(s1_valid_q && s1_end))

endmodule

[sim/tb_duration_text_parser.sv]
`timescale 1ns / 1ps

module tb_duration_text_parser;
  import dtp_pkg::*;

  localparam int unsigned BODY_MAX     = 63;
  localparam logic [30:0] MAX_SECONDS  = 31'h7FFF_FFFF;
  localparam logic        STATUS_OK    = 1'b0;
  localparam logic        STATUS_BAD   = 1'b1;
  localparam int unsigned ITEM_TARGET  = 1450;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned STUCK_LIMIT  = 3000;

  typedef logic [7:0] text_t[$];
  typedef enum logic [1:0] {SCAN_LEAD, SCAN_BODY, SCAN_TRAIL} scan_e;

  logic clk;
  logic rst_n;

  dtp_in_if  in_if();
  dtp_out_if out_if();

  duration_text_parser u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // parser state mirror
  scan_e       scan       = SCAN_LEAD;
  logic [6:0]  body_len   = '0;
  logic [30:0] lead_num   = '0;
  logic [6:0]  sec_num    = '0;
  bit          lead_dig   = 1'b0;
  bit          sec_dig    = 1'b0;
  bit          has_colon  = 1'b0;
  bit          has_mark   = 1'b0;
  bit          has_suffix = 1'b0;
  bit          bad        = 1'b0;

  dtp_result_t expected_durations[$];

  int unsigned mismatches   = 0;
  int unsigned bytes_sent   = 0;
  int unsigned stuck_cycles = 0;
  int unsigned sink_wait    = 0;
  bit          hold_request = 1'b0;
  bit          src_idle_en  = 1'b1;
  bit          sink_idle_en = 1'b1;

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
           c == CH_FF || c == CH_VT;
  endfunction

  function void clear_scan();
    scan       = SCAN_LEAD;
    body_len   = '0;
    lead_num   = '0;
    sec_num    = '0;
    lead_dig   = 1'b0;
    sec_dig    = 1'b0;
    has_colon  = 1'b0;
    has_mark   = 1'b0;
    has_suffix = 1'b0;
    bad        = 1'b0;
  endfunction

  function void scan_body_byte(logic [7:0] c);
    longint unsigned d;
    longint unsigned v;
    if (body_len <= BODY_MAX) body_len++;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      if (has_suffix) begin
        bad = 1'b1;
      end else if (has_colon || has_mark) begin
        v = 64'(sec_num) * 10 + d;
        sec_num = (v > SEC_SAT) ? SEC_SAT : v[6:0];
        sec_dig = 1'b1;
      end else begin
        if (64'(lead_num) > (64'(MAX_SECONDS) - d) / 10) bad = 1'b1;
        else lead_num = 31'(64'(lead_num) * 10 + d);
        lead_dig = 1'b1;
      end
    end else if (c == CH_COLON) begin
      if (has_colon || has_mark || has_suffix || !lead_dig) bad = 1'b1;
      has_colon = 1'b1;
    end else if (c == CH_M_LOW || c == CH_M_UP) begin
      if (has_colon || has_mark || has_suffix || !lead_dig) bad = 1'b1;
      has_mark = 1'b1;
    end else if (c == CH_S_LOW || c == CH_S_UP) begin
      if (has_colon || has_suffix) bad = 1'b1;
      has_suffix = 1'b1;
    end else begin
      bad = 1'b1;
    end
  endfunction

  function void parse_byte(logic [7:0] c);
    dtp_result_t     res;
    bit              ok;
    longint unsigned secs;
    longint unsigned total;
    if (c == CH_END) begin
      ok = !bad && body_len != 0 && body_len <= BODY_MAX && lead_dig;
      total = lead_num;
      if (has_colon || has_mark) begin
        secs = sec_dig ? sec_num : 0;
        if (has_colon && !sec_dig) ok = 1'b0;
        if (has_mark && has_suffix && !sec_dig) ok = 1'b0;
        if (secs >= SEC_LIMIT) ok = 1'b0;
        total = total * 60 + secs;
      end
      if (total > MAX_SECONDS) ok = 1'b0;
      res.total_seconds = ok ? total[30:0] : '0;
      res.parse_status  = ok ? STATUS_OK : STATUS_BAD;
      expected_durations.push_back(res);
      clear_scan();
    end else if (is_blank(c)) begin
      if (scan == SCAN_BODY) scan = SCAN_TRAIL;
    end else begin
      if (scan == SCAN_TRAIL) bad = 1'b1;
      if (scan == SCAN_LEAD) scan = SCAN_BODY;
      scan_body_byte(c);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) parse_byte(in_if.text_byte);
  end

  always @(posedge clk) begin
    dtp_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_durations.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual seconds %0d status %0d",
                 $time, out_if.total_seconds, out_if.parse_status);
      end else begin
        want = expected_durations.pop_front();
        if (out_if.total_seconds !== want.total_seconds) begin
          mismatches++;
          $display("%0t: total_seconds expected %0d actual %0d",
                   $time, want.total_seconds, out_if.total_seconds);
        end
        if (out_if.parse_status !== want.parse_status) begin
          mismatches++;
          $display("%0t: parse_status expected %0d actual %0d",
                   $time, want.parse_status, out_if.parse_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("duration_text_parser: mismatch");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result receiver
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        sink_wait = LONG_HOLD;
      end
      if (sink_wait != 0) begin
        out_if.ready <= 1'b0;
        sink_wait--;
      end else if (sink_idle_en && $urandom_range(0, 99) < 20) begin
        out_if.ready <= 1'b0;
        sink_wait = pick_gap() - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    in_if.valid     <= 1'b1;
    in_if.text_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
    gap = (src_idle_en && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_line(input text_t t);
    foreach (t[i]) send_byte(t[i]);
    send_byte(CH_END);
  endtask

  function automatic void add_str(ref text_t t, input string s);
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
  endfunction

  task automatic send_text(input string s);
    text_t t;
    add_str(t, s);
    send_line(t);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (expected_durations.size() != 0);
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_VT;
      4:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic string rand_number();
    string s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: s = $sformatf("%0d", $urandom_range(0, 99));
      5, 6:          s = $sformatf("%0d", $urandom_range(0, 999999));
      7:             s = $sformatf("%0d", 64'd2147483640 + $urandom_range(0, 15));
      8:             s = $sformatf("%0d", 35791390 + $urandom_range(0, 9));
      default:       s = $sformatf("%0d%0d", $urandom_range(1, 99999), $urandom);
    endcase
    if ($urandom_range(0, 9) == 0) s = {"0", s};
    return s;
  endfunction

  function automatic string rand_seconds();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $sformatf("%02d", $urandom_range(0, 59));
      6:                return $sformatf("%0d", $urandom_range(0, 9));
      7:                return $sformatf("%02d", $urandom_range(60, 99));
      8:                return $sformatf("%03d", $urandom_range(0, 120));
      default:          return $sformatf("%0d", $urandom_range(100, 99999));
    endcase
  endfunction

  function automatic text_t make_text();
    text_t       t;
    text_t       body;
    int unsigned kind;
    int unsigned n;
    int unsigned pos;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      n = $urandom_range(0, 10);
      repeat (n) t.push_back(8'($urandom_range(1, 255)));
      return t;
    end
    if (kind < 28) begin
      add_str(body, rand_number());
    end else if (kind < 46) begin
      add_str(body, rand_number());
      body.push_back(CH_COLON);
      add_str(body, rand_seconds());
    end else if (kind < 66) begin
      add_str(body, rand_number());
      body.push_back($urandom_range(0, 1) ? CH_M_LOW : CH_M_UP);
      if ($urandom_range(0, 3) != 0) add_str(body, rand_seconds());
      if ($urandom_range(0, 1)) body.push_back($urandom_range(0, 1) ? CH_S_LOW : CH_S_UP);
    end else if (kind < 76) begin
      add_str(body, rand_number());
      body.push_back($urandom_range(0, 1) ? CH_S_LOW : CH_S_UP);
    end else if (kind < 82) begin
      n = $urandom_range(58, 68);
      repeat (n - 2) body.push_back(CH_ZERO);
      add_str(body, $sformatf("%02d", $urandom_range(0, 99)));
    end else begin
      add_str(body, rand_number());
      body.push_back(CH_COLON);
      add_str(body, rand_seconds());
      pos = $urandom_range(0, body.size());
      case ($urandom_range(0, 3))
        0: body.insert(pos, pick_space());
        1: begin
          case ($urandom_range(0, 2))
            0:       body.insert(pos, CH_COLON);
            1:       body.insert(pos, CH_M_LOW);
            default: body.insert(pos, CH_S_UP);
          endcase
        end
        2: if (pos < body.size()) body.delete(pos);
        default: body.insert(pos, 8'($urandom_range(1, 255)));
      endcase
    end
    repeat ($urandom_range(0, 2)) t.push_back(pick_space());
    foreach (body[i]) t.push_back(body[i]);
    repeat ($urandom_range(0, 2)) t.push_back(pick_space());
    return t;
  endfunction

  task automatic test_accepted_forms();
    send_text("90");
    send_text("1:05");
    send_text("2m");
    send_text("2m30");
    send_text("2M30S");
    send_text("45s");
    send_text("45S");
    send_text("0:00");
    wait_drained();
  endtask

  task automatic test_whitespace();
    text_t t;
    t.push_back(CH_SPACE);
    t.push_back(CH_TAB);
    t.push_back(CH_LF);
    add_str(t, "42");
    t.push_back(CH_CR);
    t.push_back(CH_FF);
    t.push_back(CH_VT);
    send_line(t);
    send_text("");
    t.delete();
    t.push_back(CH_TAB);
    t.push_back(CH_SPACE);
    send_line(t);
    send_text("1 2");
    send_text(" 3m 5");
    wait_drained();
  endtask

  task automatic test_malformed();
    text_t t;
    send_text("1:2:3");
    send_text("1m2m");
    send_text("1:2m");
    send_text(":30");
    send_text("1:");
    send_text("5ms");
    send_text("s");
    send_text("1s2");
    send_text("1:30s");
    send_text("4x");
    t.push_back(8'hFF);
    send_line(t);
    t.delete();
    t.push_back(8'h80);
    send_line(t);
    wait_drained();
  endtask

  task automatic test_range_limits();
    text_t t;
    send_text("2147483647");
    send_text("2147483648");
    send_text("35791394:07");
    send_text("35791394:08");
    send_text("1:60");
    send_text("1:064");
    repeat (BODY_MAX - 1) t.push_back(CH_ZERO);
    add_str(t, "7");
    send_line(t);
    t.push_front(CH_ZERO);
    send_line(t);
    wait_drained();
  endtask

  task automatic test_output_stall();
    hold_request = 1'b1;
    src_idle_en  = 1'b0;
    for (int i = 0; i < 12; i++) send_text($sformatf("%0d", i));
    src_idle_en = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_texts();
    int unsigned texts;
    logic [1:0]  mode;
    texts = 0;
    while (bytes_sent < ITEM_TARGET) begin
      if (texts % 40 == 0) begin
        mode = 2'($urandom_range(0, 3));
        src_idle_en  = mode[0];
        sink_idle_en = mode[1];
      end
      send_line(make_text());
      texts++;
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    wait_drained();
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.text_byte = CH_END;
    rst_n           = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_accepted_forms();
    test_whitespace();
    test_malformed();
    test_range_limits();
    test_output_stall();
    test_random_texts();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_durations.size() == 0) begin
      $display("duration_text_parser: match");
    end else begin
      $display("duration_text_parser: mismatch");
    end
    $finish;
  end

endmodule
